// ----- rtl/core/pbsa_pkg.sv -----
// Shared types and constants for the packet buffer slot allocator.
// No dependencies; imported by packet_buffer_slot_allocator.
package pbsa_pkg;

	// Default pool geometry
	localparam int unsigned SLOT_COUNT_DEF   = 1024;
	localparam int unsigned BUFFER_BYTES_DEF = 2048;

	// Operation codes
	typedef enum logic {
		OP_LEASE   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// Result codes
	typedef enum logic [2:0] {
		STATUS_OK           = 3'd0,
		STATUS_EMPTY        = 3'd1,
		STATUS_DOUBLE_LEASE = 3'd2,
		STATUS_NO_HANDLE    = 3'd3,
		STATUS_INVALID      = 3'd4,
		STATUS_DOUBLE_FREE  = 3'd5
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LEASE_RD,
		S_LEASE_UPD,
		S_REL_UPD
	} state_t;

	// Command transaction
	typedef struct packed {
		op_t         operation;
		logic        handle_present;
		logic [15:0] release_slot;
	} req_t;

	// Result transaction
	typedef struct packed {
		status_t     status;
		logic [9:0]  granted_slot;
		logic [31:0] buffer_address;
		logic [10:0] available_slots;
	} rsp_t;

endpackage

// ----- rtl/core/pbsa_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; contents are undefined until written.
module pbsa_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 10,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/packet_buffer_slot_allocator.sv -----
// Packet buffer slot allocator: free-slot FIFO and in-use flags in block RAM.
// Depends on pbsa_pkg and pbsa_ram.
//
// Usage:
//   Command channel: drive req and raise start; the command is taken at a
//   clock edge where start is high and busy is low. A lease pops a free slot
//   and returns it with its buffer address; a release returns a slot.
//   Result channel: done pulses for one cycle with rsp; the receiver must
//   take it then, there is no back-pressure.
//   Config channel: cfg_data is written to the buffer base when cfg_valid
//   and cfg_ready are both high; cfg_ready follows !busy.
// Sequence (from the start accept edge to the result):
//   lease with free slots:  FIFO read, then flag read, then update
//   release with handle:    flag read, then update
//   empty, no handle, out-of-range slot: result registered straight from idle
//   One command is in flight at a time; busy is low again while the result
//   strobe is high. The two dependent RAM reads of a lease set its length.
// Reset: the FIFO reads as slots 0..SLOT_COUNT-1 and all flags as clear,
//   tracked by head/tail wrap marks, so no clearing pass is needed and a
//   command can be taken in the first cycle after reset.
module packet_buffer_slot_allocator #(
	parameter int unsigned SLOT_COUNT   = pbsa_pkg::SLOT_COUNT_DEF,
	parameter int unsigned BUFFER_BYTES = pbsa_pkg::BUFFER_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pbsa_pkg::req_t req,
	output logic           done,
	output pbsa_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [31:0]    cfg_data
);

	import pbsa_pkg::*;

	localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
	localparam logic [SW-1:0] LAST_POS = SW'(SLOT_COUNT - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(SLOT_COUNT);
	localparam logic [16:0] SLOT_LIM = 17'(SLOT_COUNT);
	localparam logic [31:0] BUF_LEN = 32'(BUFFER_BYTES);

	// State registers
	state_t        state_q, state_d;
	logic [SW-1:0] head_q, tail_q;
	logic          head_wrap_q, tail_wrap_q;
	logic [CW-1:0] fill_q, free_q;
	logic [31:0]   base_q;
	logic [SW-1:0] slot_q;
	logic          known_q;
	logic          done_q;
	rsp_t          rsp_q;

	// Next-state controls
	logic          pop_en, push_en, free_dec, free_inc;
	logic          slot_ld, known_d;
	logic [SW-1:0] slot_d;
	logic          done_d;
	rsp_t          rsp_d;
	logic [CW-1:0] free_nx;

	// RAM ports
	logic          fifo_rd_en, fifo_wr_en;
	logic [SW-1:0] fifo_rd_data;
	logic          use_rd_en, use_wr_en, use_wr_data;
	logic [SW-1:0] use_rd_addr;
	logic          use_rd_data;

	// Helpers
	logic [SW-1:0]    rel_idx, fifo_slot;
	logic             in_use;
	logic [SW+9:0]    slot_ext;
	logic [CW+10:0]   free_ext;
	logic [31:0]      lease_addr;

	pbsa_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SW)) u_fifo_ram (
		.clk    (clk),
		.wr_en  (fifo_wr_en),
		.wr_addr(tail_q),
		.wr_data(slot_q),
		.rd_en  (fifo_rd_en),
		.rd_addr(head_q),
		.rd_data(fifo_rd_data)
	);

	pbsa_ram #(.DEPTH(SLOT_COUNT), .WIDTH(1)) u_use_ram (
		.clk    (clk),
		.wr_en  (use_wr_en),
		.wr_addr(slot_q),
		.wr_data(use_wr_data),
		.rd_en  (use_rd_en),
		.rd_addr(use_rd_addr),
		.rd_data(use_rd_data)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// Decode helpers
	assign rel_idx    = req.release_slot[SW-1:0];
	assign fifo_slot  = known_q ? fifo_rd_data : head_q;
	assign in_use     = known_q & use_rd_data;
	assign slot_ext   = {10'd0, slot_q};
	assign lease_addr = base_q + 32'(slot_q) * BUF_LEN;
	assign free_nx    = free_dec ? free_q - 1'b1 : (free_inc ? free_q + 1'b1 : free_q);
	assign free_ext   = {11'd0, free_nx};

	// Sequence commands and build results
	always_comb begin
		state_d     = state_q;
		pop_en      = 1'b0;
		push_en     = 1'b0;
		free_dec    = 1'b0;
		free_inc    = 1'b0;
		slot_ld     = 1'b0;
		slot_d      = slot_q;
		known_d     = known_q;
		fifo_rd_en  = 1'b0;
		fifo_wr_en  = 1'b0;
		use_rd_en   = 1'b0;
		use_rd_addr = rel_idx;
		use_wr_en   = 1'b0;
		use_wr_data = 1'b0;
		done_d      = 1'b0;
		rsp_d       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.operation == OP_LEASE) begin
						if (fill_q == '0) begin
							done_d       = 1'b1;
							rsp_d.status = STATUS_EMPTY;
						end else begin
							// Read head entry; note whether it was ever pushed
							fifo_rd_en = 1'b1;
							slot_ld    = 1'b1;
							known_d    = tail_wrap_q || (head_q < tail_q);
							state_d    = S_LEASE_RD;
						end
					end else begin
						priority if (!req.handle_present) begin
							done_d       = 1'b1;
							rsp_d.status = STATUS_NO_HANDLE;
						end else if ({1'b0, req.release_slot} >= SLOT_LIM) begin
							done_d       = 1'b1;
							rsp_d.status = STATUS_INVALID;
						end else begin
							// Read the flag; a slot never popped reads as free
							use_rd_en = 1'b1;
							slot_ld   = 1'b1;
							slot_d    = rel_idx;
							known_d   = head_wrap_q || (rel_idx < head_q);
							state_d   = S_REL_UPD;
						end
					end
				end
				rsp_d.available_slots = free_ext[10:0];
			end
			S_LEASE_RD: begin
				// Read the flag of the popped slot
				use_rd_en   = 1'b1;
				use_rd_addr = fifo_slot;
				slot_ld     = 1'b1;
				slot_d      = fifo_slot;
				known_d     = head_wrap_q || (fifo_slot < head_q);
				state_d     = S_LEASE_UPD;
			end
			S_LEASE_UPD: begin
				pop_en  = 1'b1;
				done_d  = 1'b1;
				state_d = S_IDLE;
				if (in_use) begin
					rsp_d.status = STATUS_DOUBLE_LEASE;
				end else begin
					use_wr_en            = 1'b1;
					use_wr_data          = 1'b1;
					free_dec             = (free_q != '0);
					rsp_d.status         = STATUS_OK;
					rsp_d.granted_slot   = slot_ext[9:0];
					rsp_d.buffer_address = lease_addr;
				end
				rsp_d.available_slots = free_ext[10:0];
			end
			S_REL_UPD: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
				if (!in_use) begin
					rsp_d.status = STATUS_DOUBLE_FREE;
				end else begin
					use_wr_en    = 1'b1;
					use_wr_data  = 1'b0;
					push_en      = (fill_q < FULL_CNT);
					fifo_wr_en   = push_en;
					free_inc     = (free_q < FULL_CNT);
					rsp_d.status = STATUS_OK;
				end
				rsp_d.available_slots = free_ext[10:0];
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pointers, counts and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			head_wrap_q <= 1'b0;
			tail_wrap_q <= 1'b0;
			fill_q      <= FULL_CNT;
			free_q      <= FULL_CNT;
			base_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= done_d;
			free_q <= free_nx;
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (pop_en) begin
				head_q <= (head_q == LAST_POS) ? '0 : head_q + 1'b1;
				if (head_q == LAST_POS) begin
					head_wrap_q <= 1'b1;
				end
			end
			if (push_en) begin
				tail_q <= (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
				if (tail_q == LAST_POS) begin
					tail_wrap_q <= 1'b1;
				end
			end
			if (pop_en && !push_en) begin
				fill_q <= fill_q - 1'b1;
			end else if (push_en && !pop_en) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (slot_ld) begin
			slot_q  <= slot_d;
			known_q <= known_d;
		end
	end

`ifndef NO_ASSERTIONS
	// A result strobe follows an accepted command or a busy cycle
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without a command");

	// Counts never exceed the pool
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q <= FULL_CNT) && (fill_q <= FULL_CNT))
		else $error("slot count beyond pool size");

	// FIFO occupancy and free count are checked to be equal in every cycle
	a_fill_free: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == free_q))
		else $error("free list and free count disagree");

	// Busy never lasts longer than S_LEASE_RD followed by S_LEASE_UPD
	a_busy_len: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |=> !busy)
		else $error("command held too long");
`endif

endmodule
